/* rtl/bf5_pkg.sv */
`timescale 1ns / 1ps
package bf5_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int WIN        = 5;
  localparam int LINES      = 4;
  localparam int BORDER     = 2;

  localparam int CH_W     = 8;
  localparam int NUM_CH   = 3;
  localparam int PIX_W    = CH_W * NUM_CH;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int SLOT_W   = $clog2(LINES);
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Column sum of five samples and window sum of 25 samples.
  localparam int CS_W  = CH_W + 3;
  localparam int SUM_W = CH_W + 5;

  // floor(s / 25) == (s * DIV_MUL) >> DIV_SHIFT for every s below 25 * 256.
  localparam int DIVISOR   = 25;
  localparam int DIV_SHIFT = 18;
  localparam int DIV_MUL   = ((1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int MUL_W     = 15;
  localparam int PROD_W    = SUM_W + MUL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  addr;
  } lb_ctrl_t;

endpackage

/* rtl/box_filter_5x5_stream.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  in_tdata  {pixel_c2, pixel_c1, pixel_c0}
// out_     master     out_tvalid/out_tready out_tdata {mean_c2, mean_c1, mean_c0},
//                                          out_tlast frame_end
// cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel per cycle sustained unless a held output has filled the pipeline.
// The pipeline is line-store read, column sum, window sum, multiply by the
// reciprocal of 25 into the output register; each stage is one register.
// rst_n (synchronous) clears counters, valid bits, configuration and column
// sums; line stores and other data registers are not cleared. Each stage
// holds only while the one after it is full and held, so bubbles collapse
// and a waiting result stalls nothing until the whole pipeline is full.
module box_filter_5x5_stream (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bf5_pkg::PIX_W-1:0]      in_tdata,   // pixel_c0, pixel_c1, pixel_c2
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bf5_pkg::PIX_W-1:0]      out_tdata,  // mean_c0, mean_c1, mean_c2
  output logic                           out_tlast,  // frame_end
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bf5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bf5_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bf5_pkg::*;

  // Configuration registers
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic                color_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= WIDTH_RESET;
      height_r     <= HEIGHT_RESET;
      color_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r      <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r     <= cfg_data[HEIGHT_W-1:0];
        CFG_COLOR_MODE:   color_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective sizes: saturate to [WIN, MAX]
  logic [WIDTH_W-1:0]  w_eff, w_m1;
  logic [HEIGHT_W-1:0] h_eff, h_m1;

  always_comb begin
    if (width_r < WIDTH_W'(WIN)) w_eff = WIDTH_W'(WIN);
    else if (width_r > WIDTH_W'(MAX_WIDTH)) w_eff = WIDTH_W'(MAX_WIDTH);
    else w_eff = width_r;
    if (height_r < HEIGHT_W'(WIN)) h_eff = HEIGHT_W'(WIN);
    else if (height_r > HEIGHT_W'(MAX_HEIGHT)) h_eff = HEIGHT_W'(MAX_HEIGHT);
    else h_eff = height_r;
    w_m1 = w_eff - WIDTH_W'(1);
    h_m1 = h_eff - HEIGHT_W'(1);
  end

  // Pipeline stage control
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic en1, en2, en3, in_acc;

  assign en3       = !out_v_r || out_tready;
  assign en2       = !s3_v_r || en3;
  assign en1       = !s2_v_r || en2;
  assign in_tready = !s1_v_r || en1;
  assign in_acc    = in_tvalid && in_tready;

  // Raster position of the incoming pixel
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt, col;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt, row;
  logic [WIDTH_W-1:0]  col_inc;
  logic [HEIGHT_W-1:0] row_inc;
  logic emit, last;

  always_comb begin
    // Clamp a counter left past a size lowered in the middle of a frame
    col = ({1'b0, col_cnt_r} >= w_eff) ? w_m1[COL_W-1:0] : col_cnt_r;
    row = ({1'b0, row_cnt_r} >= h_eff) ? h_m1[ROW_W-1:0] : row_cnt_r;
    emit = (row >= ROW_W'(WIN - 1)) && (col >= COL_W'(WIN - 1));
    last = ({1'b0, row} == h_m1) && ({1'b0, col} == w_m1);

    col_inc = {1'b0, col_cnt_r} + WIDTH_W'(1);
    row_inc = {1'b0, row_cnt_r} + HEIGHT_W'(1);
    col_cnt_nxt = col_inc[COL_W-1:0];
    row_cnt_nxt = row_cnt_r;
    if (col_inc >= w_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Grayscale: store zero in channels 1 and 2
  pix_t px;
  assign px = color_mode_r ? in_tdata : {{(PIX_W - CH_W){1'b0}}, in_tdata[CH_W-1:0]};

  // Line stores: read the four older rows at this column, write this pixel
  lb_ctrl_t lb_ctrl;
  pix_t     lb_rd [LINES];

  assign lb_ctrl.rd_en = in_acc;
  assign lb_ctrl.wr_en = in_acc;
  assign lb_ctrl.slot  = row[SLOT_W-1:0];
  assign lb_ctrl.addr  = col;

  bf5_line_buf u_line_buf (
    .clk     (clk),
    .ctrl    (lb_ctrl),
    .wr_data (px),
    .rd_data (lb_rd)
  );

  // Stage 1: pixel and flags beside the line-store read data
  pix_t              s1_px_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_emit_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= px;
      s1_slot_r <= lb_ctrl.slot;
      s1_emit_r <= emit;
      s1_last_r <= last;
    end
  end

  // Rotate banks into oldest-first order, then sum each channel down the column
  pix_t            column [WIN];
  logic [CS_W-1:0] col_sum [NUM_CH];

  always_comb begin
    for (int r = 0; r < LINES; r++) begin
      column[r] = lb_rd[SLOT_W'(s1_slot_r + SLOT_W'(r))];
    end
    column[WIN-1] = s1_px_r;
    for (int k = 0; k < NUM_CH; k++) begin
      col_sum[k] = '0;
      for (int r = 0; r < WIN; r++) begin
        col_sum[k] = col_sum[k] + CS_W'(column[r][k*CH_W +: CH_W]);
      end
    end
  end

  // Stage 2: window held as five column sums per channel, newest last
  logic [CS_W-1:0] cs_r [WIN][NUM_CH];
  logic            s2_last_r;
  logic            s1_move;

  assign s1_move = s1_v_r && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      for (int c = 0; c < WIN; c++) begin
        for (int k = 0; k < NUM_CH; k++) begin
          cs_r[c][k] <= '0;
        end
      end
    end else begin
      if (en1) begin
        s2_v_r <= s1_v_r && s1_emit_r;
      end
      if (s1_move) begin
        for (int c = 0; c < WIN - 1; c++) begin
          cs_r[c] <= cs_r[c+1];
        end
        cs_r[WIN-1] <= col_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 3: window sum per channel
  logic [SUM_W-1:0] win_sum [NUM_CH];
  logic [SUM_W-1:0] sum_r [NUM_CH];
  logic             s3_last_r;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      win_sum[k] = '0;
      for (int c = 0; c < WIN; c++) begin
        win_sum[k] = win_sum[k] + SUM_W'(cs_r[c][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en2) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s2_v_r) begin
      sum_r     <= win_sum;
      s3_last_r <= s2_last_r;
    end
  end

  // Output: divide by 25 through the reciprocal multiply
  logic [PROD_W-1:0] prod [NUM_CH];
  logic [PIX_W-1:0]  mean;
  logic [PIX_W-1:0]  out_data_r;
  logic              out_last_r;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      prod[k] = PROD_W'(sum_r[k]) * PROD_W'(DIV_MUL);
      mean[k*CH_W +: CH_W] = prod[k][DIV_SHIFT +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en3) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s3_v_r) begin
      out_data_r <= mean;
      out_last_r <= s3_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Checks
  a_ready_only_when_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && !en1))
    else $error("input stalled with stage 1 free to advance");

  a_s3_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !en3) |=> (s3_v_r && $stable(s3_last_r)))
    else $error("stage 3 lost its item while the output was held");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> ((sum_r[0] <= SUM_W'(DIVISOR * 255)) && (sum_r[1] <= SUM_W'(DIVISOR * 255))
                && (sum_r[2] <= SUM_W'(DIVISOR * 255))))
    else $error("window sum out of range");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ((col_cnt_r == '0) || (col_cnt_r == $past(col_cnt_r) + COL_W'(1))))
    else $error("column counter skipped");

endmodule

/* rtl/bf5_line_buf.sv */
`timescale 1ns / 1ps
module bf5_line_buf (
  input  logic              clk,
  input  bf5_pkg::lb_ctrl_t ctrl,
  input  bf5_pkg::pix_t     wr_data,
  output bf5_pkg::pix_t     rd_data [bf5_pkg::LINES]
);
  import bf5_pkg::*;

  // One bank per buffered row; every bank reads at the same column, the
  // bank of the oldest row takes the new pixel. Read returns old data.
  pix_t line_mem [LINES][MAX_WIDTH];
  pix_t rd_data_r [LINES];

  always_ff @(posedge clk) begin
    for (int b = 0; b < LINES; b++) begin
      if (ctrl.rd_en) begin
        rd_data_r[b] <= line_mem[b][ctrl.addr];
      end
      if (ctrl.wr_en && (ctrl.slot == SLOT_W'(b))) begin
        line_mem[b][ctrl.addr] <= wr_data;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule
